>>> rtl/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'h51;
    localparam logic [7:0] MIN_LENGTH  = 8'd5;
    // length counts every frame byte but the checksum, so length - 3 bytes follow it
    localparam logic [7:0] HDR_TAIL    = 8'd3;

    localparam int RX_W   = 8;
    localparam int RES_W  = 89;
    // status bit rides on tuser, the rest fills whole bytes of tdata
    localparam int TDATA_W = ((RES_W - 1 + 7) / 8) * 8;

    // parser state, one-hot
    typedef enum logic [3:0] {
        ST_HUNT  = 4'b0001,
        ST_FUNC  = 4'b0010,
        ST_FIRST = 4'b0100,
        ST_DATA  = 4'b1000
    } parse_state_t;

    typedef struct packed {
        logic [7:0]  computed_sum;
        logic [7:0]  received_sum;
        logic [31:0] data_value;
        logic [7:0]  first_data;
        logic [7:0]  data_count;
        logic [7:0]  func_byte;
        logic [15:0] device_address;
        logic        frame_status;
    } result_t;

endpackage

>>> rtl/sfr_parser.sv
`timescale 1ns / 1ps

module sfr_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rx_beat,
    input  logic [7:0]           rx_byte,
    output logic                 res_valid,
    output sfr_pkg::result_t     res
);
    import sfr_pkg::*;

    parse_state_t state_reg, state_next;
    logic [1:0]   hunt_cnt_reg, hunt_cnt_next;
    logic [7:0]   win_reg [3];
    logic [7:0]   win_next [3];
    logic [7:0]   remain_reg, remain_next;
    logic [7:0]   sum_reg, sum_next;
    logic [15:0]  addr_reg, addr_next;
    logic [7:0]   len_reg, len_next;
    logic [7:0]   func_reg, func_next;
    logic [7:0]   first_reg, first_next;
    logic [31:0]  value_reg, value_next;
    logic         last_byte;

    assign last_byte = (remain_reg <= 8'd1);

    always_comb begin
        state_next    = state_reg;
        hunt_cnt_next = hunt_cnt_reg;
        win_next      = win_reg;
        remain_next   = remain_reg;
        sum_next      = sum_reg;
        addr_next     = addr_reg;
        len_next      = len_reg;
        func_next     = func_reg;
        first_next    = first_reg;
        value_next    = value_reg;
        res_valid     = 1'b0;

        res.frame_status   = (sum_reg != rx_byte);
        res.device_address = addr_reg;
        res.func_byte      = func_reg;
        res.data_count     = len_reg - MIN_LENGTH;
        res.first_data     = first_reg;
        res.data_value     = value_reg;
        res.received_sum   = rx_byte;
        res.computed_sum   = sum_reg;

        if (rx_beat) begin
            unique case (state_reg)
                ST_HUNT: begin
                    if (hunt_cnt_reg != 2'd3) begin
                        win_next[hunt_cnt_reg] = rx_byte;
                        hunt_cnt_next = hunt_cnt_reg + 2'd1;
                    end else if (win_reg[0] == HEADER_BYTE && rx_byte >= MIN_LENGTH) begin
                        state_next    = ST_FUNC;
                        hunt_cnt_next = 2'd0;
                        addr_next     = {win_reg[1], win_reg[2]};
                        len_next      = rx_byte;
                        remain_next   = rx_byte - HDR_TAIL;
                        sum_next      = win_reg[0] + win_reg[1] + win_reg[2] + rx_byte;
                        first_next    = '0;
                        value_next    = '0;
                    end else begin
                        // drop oldest byte, keep the other three for the next check
                        win_next[0] = win_reg[1];
                        win_next[1] = win_reg[2];
                        win_next[2] = rx_byte;
                    end
                end
                ST_FUNC, ST_FIRST, ST_DATA: begin
                    if (last_byte) begin
                        res_valid  = 1'b1;
                        state_next = ST_HUNT;
                        remain_next = '0;
                    end else begin
                        sum_next    = sum_reg + rx_byte;
                        remain_next = remain_reg - 8'd1;
                        if (state_reg == ST_FUNC) begin
                            func_next  = rx_byte;
                            state_next = ST_FIRST;
                        end else begin
                            if (state_reg == ST_FIRST) begin
                                first_next = rx_byte;
                                state_next = ST_DATA;
                            end
                            value_next = {value_reg[23:0], rx_byte};
                        end
                    end
                end
                default: state_next = ST_HUNT;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_HUNT;
            hunt_cnt_reg <= '0;
            remain_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            hunt_cnt_reg <= hunt_cnt_next;
            remain_reg   <= remain_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg   <= win_next;
        sum_reg   <= sum_next;
        addr_reg  <= addr_next;
        len_reg   <= len_next;
        func_reg  <= func_next;
        first_reg <= first_next;
        value_reg <= value_next;
    end

endmodule

>>> rtl/sfr_out_buf.sv
`timescale 1ns / 1ps

module sfr_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  sfr_pkg::result_t     in_data,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sfr_pkg::result_t     out_data,
    output logic                 skid_full
);
    import sfr_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            // no new beat can arrive while the skid stage holds one
            out_valid_next  = skid_valid_reg || in_valid;
            out_data_next   = skid_valid_reg ? skid_data_reg : in_data;
            skid_valid_next = 1'b0;
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign skid_full = skid_valid_reg;

endmodule

>>> rtl/sum_checked_frame_receiver.sv
`timescale 1ns / 1ps
// channel | dir | tdata fields, low bit up                 | tuser
// s_      | in  | rx_byte[7:0]                              | -
// m_      | out | device_address, func_byte, data_count,    | frame_status
//         |     | first_data, data_value, received_sum,     |
//         |     | computed_sum                              |
//
// One byte is taken per cycle while s_tready is high; the whole parse step sits
// between the parser state registers and the output register, so a result beat is
// registered there (or in the skid stage while the output is held) as its checksum byte is accepted.
// Reset (aresetn low, synchronous) returns the parser to header hunt.
// Output register plus skid stage: s_tready drops only when both hold beats.

module sum_checked_frame_receiver (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [sfr_pkg::RX_W-1:0]    s_tdata,   // [7:0] rx_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sfr_pkg::TDATA_W-1:0] m_tdata,   // [15:0] device_address, [23:16] func_byte,
                                                   // [31:24] data_count, [39:32] first_data,
                                                   // [71:40] data_value, [79:72] received_sum,
                                                   // [87:80] computed_sum
    output logic                        m_tuser    // [0] frame_status
);
    import sfr_pkg::*;

    logic    rx_beat;
    logic    res_valid;
    result_t res;
    result_t out_res;
    logic    skid_full;

    assign rx_beat = s_tvalid && s_tready;

    sfr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rx_beat   (rx_beat),
        .rx_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    sfr_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res),
        .skid_full (skid_full)
    );

    // struct is declared MSB-first: status sits in bit 0, the rest fills tdata
    assign m_tdata = out_res[RES_W-1:1];
    assign m_tuser = out_res.frame_status;

    // skid stage only fills behind a held output beat
    assert property (@(posedge aclk) disable iff (!aresetn) skid_full |-> m_tvalid)
        else $error("skid holds a beat while output is empty");

    // status must agree with the two sums it reports
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_res.frame_status == (out_res.received_sum != out_res.computed_sum)))
        else $error("frame status disagrees with sums");

    // a frame without data reports no data bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res.data_count == 8'd0) |->
        (out_res.first_data == 8'd0 && out_res.data_value == 32'd0))
        else $error("data fields set on empty frame");

    // a result beat ends the frame: input side is ready again unless both stages are full
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !(m_tvalid && !m_tready)) |=> s_tready)
        else $error("input stalled with free output stage");

endmodule
